@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Two forms of a clocked implication check, both disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked on the same edge as the antecedent
`define LAW_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked on the edge after the antecedent
`define LAW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/law3d_pkg.sv @@
// ---------------------------------------------------------------------------
// law3d_pkg
// Types and fixed constants of the 3D lattice aggregation walker.
// ---------------------------------------------------------------------------
package law3d_pkg;

  // fixed field widths and the percent scale
  localparam int POR_W     = 7;
  localparam int CFG_W     = 8;
  localparam int RETRY_W   = 8;
  localparam int PCT_SCALE = 100;

  // register reset values
  localparam logic [POR_W-1:0]   TARGET_RST = 7'd20;
  localparam logic [RETRY_W-1:0] RETRY_RST  = 8'd120;

  // configuration register indexes
  localparam logic REG_TARGET_POROSITY   = 1'b0;
  localparam logic REG_SPAWN_RETRY_LIMIT = 1'b1;

  // grid cell codes
  typedef enum logic [1:0] {
    CELL_EMPTY = 2'd0,
    CELL_AGG   = 2'd1,
    CELL_WALK  = 2'd2
  } cell_t;

  // result event codes
  typedef enum logic [1:0] {
    EV_REJECT   = 2'd0,
    EV_MOVED    = 2'd1,
    EV_STUCK    = 2'd2,
    EV_FINISHED = 2'd3
  } event_t;

  // decoded unit offset
  typedef enum logic [1:0] {
    STEP_ZERO = 2'd0,
    STEP_POS  = 2'd1,
    STEP_NEG  = 2'd2
  } step_t;

  // one input beat, spawn_dx in the lowest bits
  typedef struct packed {
    logic [1:0] move_dz;
    logic [1:0] move_dy;
    logic [1:0] move_dx;
    logic [1:0] spawn_dz;
    logic [1:0] spawn_dy;
    logic [1:0] spawn_dx;
  } item_t;

  // porosity tracker status
  typedef struct packed {
    logic             busy;
    logic [POR_W-1:0] porosity;
  } poro_stat_t;

  // result hand-over from sequencer to output register
  typedef struct packed {
    logic   load;
    event_t ev;
  } res_ctl_t;

  // 2-bit two's complement offset; -2 saturates to -1
  function automatic step_t to_step(logic [1:0] v);
    step_t s;
    unique case (v)
      2'b00:   s = STEP_ZERO;
      2'b01:   s = STEP_POS;
      default: s = STEP_NEG;
    endcase
    return s;
  endfunction

endpackage

@@ hw/rtl/law3d_ram.sv @@
// ---------------------------------------------------------------------------
// law3d_ram
// Generic single-port RAM, one write or read per cycle, registered read.
// ---------------------------------------------------------------------------
module law3d_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hw/rtl/law3d_poro.sv @@
// ---------------------------------------------------------------------------
// law3d_poro
// Aggregate counter with running porosity = count*100 / interior cells,
// kept as quotient and remainder; one compare-and-subtract per cycle.
// ---------------------------------------------------------------------------
module law3d_poro import law3d_pkg::*; #(
  parameter int GRID_EDGE = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           bump,
  output poro_stat_t                     stat,
  output logic [3*$clog2(GRID_EDGE):0]   count
);

  localparam int CW       = $clog2(GRID_EDGE);
  localparam int CNT_W    = 3 * CW + 1;
  localparam int INTERIOR = (GRID_EDGE - 2) * (GRID_EDGE - 2) * (GRID_EDGE - 2);
  localparam int REM_W    = $clog2(INTERIOR + PCT_SCALE);
  localparam int POR_RST  = PCT_SCALE / INTERIOR;
  localparam int REM_RST  = PCT_SCALE % INTERIOR;

  logic [REM_W-1:0] rem;
  logic [POR_W-1:0] por;
  logic             busy;

  // add 100 to the remainder, then subtract the interior size until it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CNT_W'(1);
      por   <= POR_W'(POR_RST);
      rem   <= REM_W'(REM_RST);
      busy  <= 1'b0;
    end else if (bump) begin
      count <= count + CNT_W'(1);
      rem   <= rem + REM_W'(PCT_SCALE);
      busy  <= 1'b1;
    end else if (busy) begin
      if (rem >= REM_W'(INTERIOR)) begin
        rem <= rem - REM_W'(INTERIOR);
        por <= por + POR_W'(1);
      end else begin
        busy <= 1'b0;
      end
    end
  end

  assign stat.busy     = busy;
  assign stat.porosity = por;

endmodule

@@ hw/rtl/law3d_seq.sv @@
// ---------------------------------------------------------------------------
// law3d_seq
// Step sequencer: grid clearing, spawn, 27-cell neighbourhood scan, stick
// or move, all through the one grid memory port.
// ---------------------------------------------------------------------------
module law3d_seq import law3d_pkg::*; #(
  parameter int GRID_EDGE = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // input side
  input  logic                          in_valid,
  output logic                          in_ready,
  input  item_t                         item,
  // configuration
  input  logic [POR_W-1:0]              target_porosity,
  input  logic [RETRY_W-1:0]            spawn_retry_limit,
  // porosity tracker
  input  poro_stat_t                    pstat,
  input  logic [3*$clog2(GRID_EDGE):0]  count,
  output logic                          bump,
  // grid memory
  output logic                          mem_we,
  output logic [3*$clog2(GRID_EDGE)-1:0] mem_addr,
  output logic [1:0]                    mem_wdata,
  input  logic [1:0]                    mem_rdata,
  // result
  input  logic                          out_free,
  output res_ctl_t                      res,
  output logic [$clog2(GRID_EDGE)-1:0]  pos_x,
  output logic [$clog2(GRID_EDGE)-1:0]  pos_y,
  output logic [$clog2(GRID_EDGE)-1:0]  pos_z
);

  localparam int CW     = $clog2(GRID_EDGE);
  localparam int CNT_W  = 3 * CW + 1;
  localparam int ADDR_W = 3 * CW;
  localparam int MID    = GRID_EDGE / 2;
  localparam int HI     = GRID_EDGE - 2;
  localparam logic [ADDR_W-1:0] CENTRE_ADDR = {CW'(MID), CW'(MID), CW'(MID)};

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SPAWN_RD, S_SPAWN_CHK, S_SCAN, S_SCAN_END,
    S_DECIDE, S_POR_WAIT, S_MOVE_RD, S_MOVE_CHK, S_DONE
  } state_t;

  // spawn coordinate: centre + offset * count, clamped to the interior
  function automatic logic [CW-1:0] spawn_axis(step_t s, logic [CNT_W-1:0] n);
    logic [CW-1:0] r;
    unique case (s)
      STEP_POS: r = (n > CNT_W'(HI - MID)) ? CW'(HI) : CW'(MID) + n[CW-1:0];
      STEP_NEG: r = (n >= CNT_W'(MID)) ? CW'(1) : CW'(MID) - n[CW-1:0];
      default:  r = CW'(MID);
    endcase
    return r;
  endfunction

  // one walker step, saturating at the interior bounds
  function automatic logic [CW-1:0] move_axis(step_t s, logic [CW-1:0] p);
    logic [CW-1:0] r;
    unique case (s)
      STEP_POS: r = (p == CW'(HI)) ? p : p + CW'(1);
      STEP_NEG: r = (p == CW'(1)) ? p : p - CW'(1);
      default:  r = p;
    endcase
    return r;
  endfunction

  state_t             state;
  logic [ADDR_W-1:0]  clr_addr;
  step_t              sdx, sdy, sdz, mdx, mdy, mdz;
  logic [CW-1:0]      sx, sy, sz;
  logic               present;
  logic               finished;
  logic [RETRY_W-1:0] retries;
  logic [1:0]         ox, oy, oz;
  logic               chk_vld;
  logic               chk_ctr;
  logic               touch;
  logic [1:0]         here_code;
  event_t             ev;

  logic [CW-1:0]      spx, spy, spz;
  logic [CW-1:0]      nbx, nby, nbz;
  logic               at_target;
  logic               reject;
  logic               scan_last;

  assign spx = spawn_axis(sdx, count);
  assign spy = spawn_axis(sdy, count);
  assign spz = spawn_axis(sdz, count);
  assign nbx = pos_x + CW'(ox) - CW'(1);
  assign nby = pos_y + CW'(oy) - CW'(1);
  assign nbz = pos_z + CW'(oz) - CW'(1);

  assign at_target = (pstat.porosity >= target_porosity);
  assign reject    = (mem_rdata != CELL_EMPTY) && (retries < spawn_retry_limit);
  assign scan_last = (ox == 2'd2) && (oy == 2'd2) && (oz == 2'd2);
  assign in_ready  = (state == S_IDLE);
  assign bump      = (state == S_DECIDE) && touch && (here_code != CELL_AGG);

  // grid port control
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = {pos_z, pos_y, pos_x};
    mem_wdata = CELL_EMPTY;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = (clr_addr == CENTRE_ADDR) ? CELL_AGG : CELL_EMPTY;
      end
      S_SPAWN_RD: mem_addr = {spz, spy, spx};
      S_SPAWN_CHK: begin
        mem_addr  = {sz, sy, sx};
        mem_we    = !reject && (mem_rdata == CELL_EMPTY);
        mem_wdata = CELL_WALK;
      end
      S_SCAN: mem_addr = {nbz, nby, nbx};
      S_DECIDE: begin
        mem_we    = touch ? (here_code != CELL_AGG) : (here_code == CELL_WALK);
        mem_wdata = touch ? CELL_AGG : CELL_EMPTY;
      end
      S_MOVE_CHK: begin
        mem_we    = (mem_rdata == CELL_EMPTY);
        mem_wdata = CELL_WALK;
      end
      default: ;
    endcase
  end

  assign res.load = (state == S_DONE) && out_free;
  assign res.ev   = ev;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      present   <= 1'b0;
      finished  <= 1'b0;
      retries   <= '0;
      pos_x     <= '0;
      pos_y     <= '0;
      pos_z     <= '0;
      chk_vld   <= 1'b0;
      ev        <= EV_REJECT;
    end else begin
      unique case (state)
        // one cell per cycle, centre seeded as aggregate
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_valid) begin
            sdx <= to_step(item.spawn_dx);
            sdy <= to_step(item.spawn_dy);
            sdz <= to_step(item.spawn_dz);
            mdx <= to_step(item.move_dx);
            mdy <= to_step(item.move_dy);
            mdz <= to_step(item.move_dz);
            ox      <= 2'd0;
            oy      <= 2'd0;
            oz      <= 2'd0;
            touch   <= 1'b0;
            chk_vld <= 1'b0;
            if (finished || at_target) begin
              finished <= 1'b1;
              ev       <= EV_FINISHED;
              state    <= S_DONE;
            end else if (!present) begin
              state <= S_SPAWN_RD;
            end else begin
              state <= S_SCAN;
            end
          end
        end

        S_SPAWN_RD: begin
          sx    <= spx;
          sy    <= spy;
          sz    <= spz;
          state <= S_SPAWN_CHK;
        end

        // occupied spawn cell: reject until the retry limit forces it
        S_SPAWN_CHK: begin
          if (reject) begin
            retries <= retries + RETRY_W'(1);
            ev      <= EV_REJECT;
            state   <= S_DONE;
          end else begin
            retries <= '0;
            pos_x   <= sx;
            pos_y   <= sy;
            pos_z   <= sz;
            present <= 1'b1;
            state   <= S_SCAN;
          end
        end

        // issue one neighbourhood read per cycle, check the previous one
        S_SCAN: begin
          if (chk_vld) begin
            if (chk_ctr) begin
              here_code <= mem_rdata;
            end else if (mem_rdata == CELL_AGG) begin
              touch <= 1'b1;
            end
          end
          chk_vld <= 1'b1;
          chk_ctr <= (ox == 2'd1) && (oy == 2'd1) && (oz == 2'd1);
          if (ox == 2'd2) begin
            ox <= 2'd0;
            if (oy == 2'd2) begin
              oy <= 2'd0;
              oz <= oz + 2'd1;
            end else begin
              oy <= oy + 2'd1;
            end
          end else begin
            ox <= ox + 2'd1;
          end
          if (scan_last) begin
            state <= S_SCAN_END;
          end
        end

        S_SCAN_END: begin
          if (mem_rdata == CELL_AGG) begin
            touch <= 1'b1;
          end
          chk_vld <= 1'b0;
          state   <= S_DECIDE;
        end

        S_DECIDE: begin
          if (touch) begin
            present <= 1'b0;
            ev      <= EV_STUCK;
            state   <= S_POR_WAIT;
          end else begin
            pos_x <= move_axis(mdx, pos_x);
            pos_y <= move_axis(mdy, pos_y);
            pos_z <= move_axis(mdz, pos_z);
            ev    <= EV_MOVED;
            state <= S_MOVE_RD;
          end
        end

        S_POR_WAIT: begin
          if (!pstat.busy) begin
            if (at_target) begin
              finished <= 1'b1;
            end
            state <= S_DONE;
          end
        end

        S_MOVE_RD: state <= S_MOVE_CHK;

        S_MOVE_CHK: state <= S_DONE;

        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/lattice_aggregation_walker_3d_core.sv @@
// ---------------------------------------------------------------------------
// lattice_aggregation_walker_3d_core
// 3D lattice diffusion-limited aggregation stepper, one result beat per
// input beat.
// ---------------------------------------------------------------------------
// After reset the block clears all 2**(3*clog2(GRID_EDGE)) cells of its grid
// (4096 at the default edge of 16) and takes no input beat meanwhile;
// configuration writes are taken at any time. After an input beat is accepted,
// s_tready returns in the same cycle in which the result beat appears on
// m_tvalid. A beat that spawns a walker also scans and sticks or moves it.
// A stick that adds an aggregate cell waits for the porosity update, one
// subtraction of the interior size at a time (at most one at the default edge,
// more on smaller grids). A move or stick reads the 27 cells of the
// neighbourhood one after another through the single port of the grid memory.
// One item is in work at a time; a previous result still waiting in the output
// register holds the block until it is taken, and the finished result waits in
// the output register while the next beat is accepted.
// ---------------------------------------------------------------------------
module lattice_aggregation_walker_3d_core import law3d_pkg::*; #(
  parameter int GRID_EDGE = 16
) (
  input  logic              clk,
  input  logic              rst,
  // input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  // spawn_dx[1:0] spawn_dy[3:2] spawn_dz[5:4] move_dx[7:6] move_dy[9:8]
  // move_dz[11:10], zero above
  input  logic [15:0]       s_tdata,
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  // walker_x[3:0] walker_y[7:4] walker_z[11:8] aggregate_total[23:12]
  // porosity_now[30:24], zero above
  output logic [31:0]       m_tdata,
  // event_res[1:0]
  output logic [1:0]        m_tuser,
  // configuration
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  `include "assert_macros.svh"

  localparam int CW     = $clog2(GRID_EDGE);
  localparam int CNT_W  = 3 * CW + 1;
  localparam int ADDR_W = 3 * CW;
  localparam int DEPTH  = 1 << ADDR_W;

  logic [POR_W-1:0]   target_porosity;
  logic [RETRY_W-1:0] spawn_retry_limit;
  item_t              item;
  poro_stat_t         pstat;
  logic [CNT_W-1:0]   count;
  logic               bump;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  logic [1:0]         mem_wdata;
  logic [1:0]         mem_rdata;
  logic               out_free;
  res_ctl_t           res;
  logic [CW-1:0]      pos_x, pos_y, pos_z;

  assign item = item_t'(s_tdata[11:0]);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_porosity   <= TARGET_RST;
      spawn_retry_limit <= RETRY_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TARGET_POROSITY:   target_porosity   <= cfg_wdata[POR_W-1:0];
        REG_SPAWN_RETRY_LIMIT: spawn_retry_limit <= cfg_wdata[RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  law3d_ram #(
    .WIDTH (2),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  law3d_poro #(
    .GRID_EDGE (GRID_EDGE)
  ) u_poro (
    .clk   (clk),
    .rst   (rst),
    .bump  (bump),
    .stat  (pstat),
    .count (count)
  );

  law3d_seq #(
    .GRID_EDGE (GRID_EDGE)
  ) u_seq (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (s_tvalid),
    .in_ready          (s_tready),
    .item              (item),
    .target_porosity   (target_porosity),
    .spawn_retry_limit (spawn_retry_limit),
    .pstat             (pstat),
    .count             (count),
    .bump              (bump),
    .mem_we            (mem_we),
    .mem_addr          (mem_addr),
    .mem_wdata         (mem_wdata),
    .mem_rdata         (mem_rdata),
    .out_free          (out_free),
    .res               (res),
    .pos_x             (pos_x),
    .pos_y             (pos_y),
    .pos_z             (pos_z)
  );

  // output register
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      m_tuser <= res.ev;
      m_tdata <= {1'b0, pstat.porosity, 12'(count), 4'(pos_z), 4'(pos_y), 4'(pos_x)};
    end
  end

  // checks
  `LAW_ASSERT_SAME(a_no_load_on_accept, clk, rst, s_tvalid && s_tready, !res.load,
                   "result loaded in the cycle an input beat was accepted")
  `LAW_ASSERT_SAME(a_poro_idle_on_accept, clk, rst, s_tvalid && s_tready, !pstat.busy,
                   "input beat accepted while porosity update in progress")
  `LAW_ASSERT_NEXT(a_load_shows, clk, rst, res.load,
                   m_tvalid && (m_tdata[30:24] <= 7'd100),
                   "loaded result not shown or porosity out of range")

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3D lattice aggregation walker. A scoreboard
// class keeps its own copy of the cell grid, walker and registers, predicts
// the result beat of every accepted input beat and checks the result stream
// against it in order. Directed beats cover the seed, rejected and forced
// spawns and the offset encodings; random beats, mostly pulled towards the
// centre, grow the aggregate until the run finishes.
// ---------------------------------------------------------------------------

localparam int LATTICE_EDGE = 16;

// expected result beat
typedef struct packed {
  law3d_pkg::event_t ev;
  logic [3:0]        x;
  logic [3:0]        y;
  logic [3:0]        z;
  logic [11:0]       agg;
  logic [6:0]        por;
} step_res_t;

class dla_scoreboard;
  localparam int CELLS    = LATTICE_EDGE * LATTICE_EDGE * LATTICE_EDGE;
  localparam int INTERIOR = (LATTICE_EDGE - 2) * (LATTICE_EDGE - 2) * (LATTICE_EDGE - 2);
  localparam int MID      = LATTICE_EDGE / 2;

  law3d_pkg::cell_t grid [CELLS];
  bit               walker_on;
  int               pos [3];
  int               agg_count;
  int               retries;
  bit               done;
  int               target_pct;
  int               retry_limit;
  step_res_t        result_q [$];
  int               errors;

  function new();
    foreach (grid[i]) grid[i] = law3d_pkg::CELL_EMPTY;
    grid[cell_at(MID, MID, MID)] = law3d_pkg::CELL_AGG;
    walker_on   = 1'b0;
    pos         = '{0, 0, 0};
    agg_count   = 1;
    retries     = 0;
    done        = 1'b0;
    target_pct  = law3d_pkg::TARGET_RST;
    retry_limit = law3d_pkg::RETRY_RST;
    errors      = 0;
  endfunction

  function int cell_at(int x, int y, int z);
    return x + LATTICE_EDGE * (y + LATTICE_EDGE * z);
  endfunction

  // 2-bit offset, binary 10 saturates to -1
  function int offset_of(logic [1:0] v);
    case (v)
      2'b00:   return 0;
      2'b01:   return 1;
      default: return -1;
    endcase
  endfunction

  function int keep_inside(int v);
    if (v < 1) return 1;
    if (v > LATTICE_EDGE - 2) return LATTICE_EDGE - 2;
    return v;
  endfunction

  function int porosity();
    return agg_count * law3d_pkg::PCT_SCALE / INTERIOR;
  endfunction

  function bit near_aggregate(int x, int y, int z);
    for (int dz = -1; dz <= 1; dz++)
      for (int dy = -1; dy <= 1; dy++)
        for (int dx = -1; dx <= 1; dx++) begin
          if (dx == 0 && dy == 0 && dz == 0) continue;
          if (grid[cell_at(x + dx, y + dy, z + dz)] == law3d_pkg::CELL_AGG) return 1'b1;
        end
    return 1'b0;
  endfunction

  function void write_reg(logic addr, logic [7:0] data);
    if (addr == law3d_pkg::REG_TARGET_POROSITY) target_pct = data[6:0];
    else retry_limit = data;
  endfunction

  function void log_result(law3d_pkg::event_t ev);
    step_res_t r;
    r.ev  = ev;
    r.x   = 4'(pos[0]);
    r.y   = 4'(pos[1]);
    r.z   = 4'(pos[2]);
    r.agg = 12'(agg_count);
    r.por = 7'(porosity());
    result_q.push_back(r);
  endfunction

  // one walker step per accepted beat
  function void note_item(law3d_pkg::item_t it);
    int p [3];
    int spawn_off [3];
    int step_off [3];
    int here;
    spawn_off = '{offset_of(it.spawn_dx), offset_of(it.spawn_dy), offset_of(it.spawn_dz)};
    step_off  = '{offset_of(it.move_dx), offset_of(it.move_dy), offset_of(it.move_dz)};

    // finished state is sticky
    if (done || porosity() >= target_pct) begin
      done = 1'b1;
      log_result(law3d_pkg::EV_FINISHED);
      return;
    end

    // spawn, rejected on an occupied cell until the retry limit forces it
    if (!walker_on) begin
      foreach (p[a]) p[a] = keep_inside(MID + spawn_off[a] * agg_count);
      here = cell_at(p[0], p[1], p[2]);
      if (grid[here] != law3d_pkg::CELL_EMPTY && retries < retry_limit) begin
        retries++;
        log_result(law3d_pkg::EV_REJECT);
        return;
      end
      retries = 0;
      if (grid[here] == law3d_pkg::CELL_EMPTY) grid[here] = law3d_pkg::CELL_WALK;
      pos       = p;
      walker_on = 1'b1;
    end

    // stick next to the aggregate; no new count when already on it
    here = cell_at(pos[0], pos[1], pos[2]);
    if (near_aggregate(pos[0], pos[1], pos[2])) begin
      if (grid[here] != law3d_pkg::CELL_AGG) begin
        grid[here] = law3d_pkg::CELL_AGG;
        agg_count++;
      end
      walker_on = 1'b0;
      if (porosity() >= target_pct) done = 1'b1;
      log_result(law3d_pkg::EV_STUCK);
      return;
    end

    // saturating step; only a walker mark is cleared behind it
    if (grid[here] == law3d_pkg::CELL_WALK) grid[here] = law3d_pkg::CELL_EMPTY;
    foreach (pos[a]) pos[a] = keep_inside(pos[a] + step_off[a]);
    here = cell_at(pos[0], pos[1], pos[2]);
    if (grid[here] == law3d_pkg::CELL_EMPTY) grid[here] = law3d_pkg::CELL_WALK;
    log_result(law3d_pkg::EV_MOVED);
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $time, msg);
  endfunction

  function void check_result(logic [31:0] data, logic [1:0] user);
    step_res_t want;
    bit        bad;
    if (result_q.size() == 0) begin
      flag($sformatf("result beat with nothing expected: event %0d tdata %h", user, data));
      return;
    end
    want = result_q.pop_front();
    bad  = (user != want.ev) || (data[3:0] != want.x) || (data[7:4] != want.y) ||
           (data[11:8] != want.z) || (data[23:12] != want.agg) ||
           (data[30:24] != want.por) || (data[31] != 1'b0);
    if (bad)
      flag($sformatf({"mismatch: expected ev %0d xyz %0d,%0d,%0d agg %0d por %0d, ",
                      "got ev %0d xyz %0d,%0d,%0d agg %0d por %0d (tdata %h)"},
                     want.ev, want.x, want.y, want.z, want.agg, want.por,
                     user, data[3:0], data[7:4], data[11:8], data[23:12], data[30:24],
                     data));
  endfunction

  function int pending();
    return result_q.size();
  endfunction

  function int close_out();
    if (result_q.size() != 0)
      flag($sformatf("%0d expected result beats never arrived", result_q.size()));
    return errors;
  endfunction
endclass

module tb_top;
  import law3d_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 60;
  localparam int MID         = LATTICE_EDGE / 2;

  // defaults from reset: rejects on the seed, first stick, all offset codes
  localparam item_t SEED_ITEMS [16] = '{
    12'h000, 12'h000, 12'h015, 12'h02A, 12'hFFF, 12'h555, 12'hAAA, 12'h540,
    12'hA80, 12'hFC0, 12'h03F, 12'h7E4, 12'h819, 12'h000, 12'hC3C, 12'h6D9
  };
  // zero spawn offset with a retry limit of zero: forced onto the seed
  localparam item_t FORCED_ITEMS [6] = '{
    12'h000, 12'h540, 12'hFC0, 12'h000, 12'hA80, 12'h000
  };

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [15:0]      s_tdata   = '0;
  logic             m_tvalid;
  logic             m_tready  = 1'b0;
  logic [31:0]      m_tdata;
  logic [1:0]       m_tuser;
  logic             cfg_we    = 1'b0;
  logic             cfg_addr  = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  dla_scoreboard walk_sb;
  bit            idling      = 1'b1;
  int            centre_pull = 60;
  int unsigned   cycles      = 0;

  lattice_aggregation_walker_3d_core #(
    .GRID_EDGE(LATTICE_EDGE)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // mostly no gap, some short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!idling || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [1:0] towards(int from);
    if (from < MID) return 2'b01;
    if (from > MID) return ($urandom_range(0, 1) != 0) ? 2'b11 : 2'b10;
    return 2'b00;
  endfunction

  // random offsets, moves pulled towards the centre to grow the aggregate
  function automatic item_t random_item();
    item_t it;
    it = item_t'(12'($urandom));
    if ($urandom_range(0, 99) < centre_pull) it.move_dx = towards(walk_sb.pos[0]);
    if ($urandom_range(0, 99) < centre_pull) it.move_dy = towards(walk_sb.pos[1]);
    if ($urandom_range(0, 99) < centre_pull) it.move_dz = towards(walk_sb.pos[2]);
    return it;
  endfunction

  // result side: check accepted beats, stall at random
  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) walk_sb.check_result(m_tdata, m_tuser);
      if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        stall = gap_len();
      end
    end
  end

  // one input beat; tvalid stays high unless a gap follows
  task automatic send_beat(item_t it);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, it};
    do @(posedge clk); while (!s_tready);
    walk_sb.note_item(it);
  endtask

  task automatic send_random(int n);
    repeat (n) send_beat(random_item());
  endtask

  // wait for every result, then let the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (walk_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_regs(logic [CFG_W-1:0] target, logic [CFG_W-1:0] limit);
    walk_sb.write_reg(REG_TARGET_POROSITY, target);
    walk_sb.write_reg(REG_SPAWN_RETRY_LIMIT, limit);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_TARGET_POROSITY;
    cfg_wdata <= target;
    @(posedge clk);
    cfg_addr  <= REG_SPAWN_RETRY_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    int target;
    walk_sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset values of both registers
    foreach (SEED_ITEMS[i]) send_beat(SEED_ITEMS[i]);
    send_random(100);
    drain();

    // retry limit zero, target 100 written with bit 7 set; no idling here
    set_regs(8'd228, 8'd0);
    idling = 1'b0;
    foreach (FORCED_ITEMS[i]) send_beat(FORCED_ITEMS[i]);
    send_random(120);
    drain();
    idling = 1'b1;

    // target above 100 never finishes, largest retry limit
    set_regs(8'd127, 8'd255);
    send_random(120);
    drain();

    set_regs(8'd50, 8'd2);
    send_random(120);
    drain();

    // next percent step as target, strong pull so the run finishes
    target      = walk_sb.porosity() + 1;
    centre_pull = 90;
    set_regs(8'(target), 8'($urandom_range(0, 255)));
    for (int n = 0; n < 400 && !walk_sb.done; n++) send_beat(random_item());
    send_random(4);
    drain();

    // target zero finishes at once
    set_regs(8'd0, 8'd120);
    send_random(4);
    drain();

    if (walk_sb.close_out() == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
